### src/assert_macros.svh
// Assertion macros used by the queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define RRQ_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// Antecedent in a cycle requires the consequent in the next cycle.
`define RRQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### src/rrq_pkg.sv
// Package with the sizes, codes and types of the record ring queue.
package rrq_pkg;

    localparam int SLOTS      = 16;
    localparam int SLOT_BYTES = 256;

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int OFF_W  = $clog2(SLOT_BYTES + 1);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int ADDR_W = $clog2(SLOTS * SLOT_BYTES);

    localparam int OP_W   = 2;
    localparam int STAT_W = 2;
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 9;
    localparam int OCC_W  = 5;

    localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
    localparam logic [OP_W-1:0] OP_COMMIT = 2'd1;
    localparam logic [OP_W-1:0] OP_POP    = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd2;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd3;

    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] wdata;
    } t_store_req;

    function automatic logic [SLOT_W-1:0] ring_next(input logic [SLOT_W-1:0] pos);
        logic [SLOT_W-1:0] nxt;
        if (pos == SLOT_W'(SLOTS - 1)) begin
            nxt = '0;
        end else begin
            nxt = pos + SLOT_W'(1);
        end
        return nxt;
    endfunction

    function automatic logic [ADDR_W-1:0] byte_addr(input logic [SLOT_W-1:0] slot,
                                                    input logic [OFF_W-1:0] off);
        return ADDR_W'(ADDR_W'(slot) * ADDR_W'(SLOT_BYTES) + ADDR_W'(off));
    endfunction

endpackage

### src/rrq_byte_store.sv
// Single-port byte memory holding the record slots, with a registered read.
module rrq_byte_store
    import rrq_pkg::*;
(
    input  logic              i_clk,
    input  t_store_req        i_req,
    output logic [BYTE_W-1:0] o_rd_data
);

    logic [BYTE_W-1:0] mem [SLOTS*SLOT_BYTES];
    logic [BYTE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.rd_en) begin
            r_rd_data <= mem[i_req.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### src/record_ring_queue.sv
// Top level of the record ring queue: control, slot lengths and result register.
// A request that pushes a byte, commits a record or pops from an empty queue or an
// empty record has its result offered in the cycle after it is accepted; a pop that
// returns a byte has the byte read into the synchronous memory's read register and
// then waits in the read state before its result is offered. A new request is taken
// once no read is pending and the result register is free or is being taken in the
// same cycle. The queue holds 16 slots of 256 bytes each and needs no clearing pass after reset.
`include "assert_macros.svh"

module record_ring_queue
    import rrq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [OP_W-1:0]   i_op,
    input  logic [BYTE_W-1:0] i_data_byte,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [STAT_W-1:0] o_status,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic              o_record_end,
    output logic [LEN_W-1:0]  o_head_length,
    output logic [OCC_W-1:0]  o_occupancy
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic              r_state, n_state;
    logic [SLOT_W-1:0] r_write_slot, n_write_slot;
    logic [SLOT_W-1:0] r_read_slot, n_read_slot;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [OFF_W-1:0]  r_write_offset, n_write_offset;
    logic [OFF_W-1:0]  r_read_offset, n_read_offset;
    logic              r_dropping, n_dropping;
    logic [OFF_W-1:0]  r_slot_len [SLOTS];

    logic              r_out_valid, n_out_valid;
    logic [STAT_W-1:0] r_status, n_status;
    logic              r_rec_end, n_rec_end;
    logic [LEN_W-1:0]  r_head_len, n_head_len;
    logic              r_use_mem, n_use_mem;

    logic              accept;
    logic              drop;
    logic              len_we;
    logic [OFF_W-1:0]  head_len;
    logic [OFF_W-1:0]  rd_next;
    t_store_req        store_req;
    logic [BYTE_W-1:0] rd_data;

    assign o_in_ready = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;
    assign drop       = r_dropping || ((r_write_offset == '0) && (r_count >= CNT_W'(SLOTS)));
    assign head_len   = r_slot_len[r_read_slot];
    assign rd_next    = r_read_offset + OFF_W'(1);

    always_comb begin
        n_state        = ST_IDLE;
        n_write_slot   = r_write_slot;
        n_read_slot    = r_read_slot;
        n_count        = r_count;
        n_write_offset = r_write_offset;
        n_read_offset  = r_read_offset;
        n_dropping     = r_dropping;
        n_status       = STAT_OK;
        n_rec_end      = 1'b0;
        n_head_len     = '0;
        n_use_mem      = 1'b0;
        len_we         = 1'b0;
        store_req      = '0;
        n_out_valid    = r_out_valid && !i_out_ready;
        if (r_state == ST_READ) begin
            n_out_valid = 1'b1;
        end
        if (accept) begin
            unique case (i_op)
                OP_PUSH: begin
                    if (drop) begin
                        n_dropping = 1'b1;
                        n_status   = STAT_FULL;
                    end else if (r_write_offset >= OFF_W'(SLOT_BYTES)) begin
                        n_status = STAT_OVERFLOW;
                    end else begin
                        store_req.wr_en = 1'b1;
                        store_req.addr  = byte_addr(r_write_slot, r_write_offset);
                        store_req.wdata = i_data_byte;
                        n_write_offset  = r_write_offset + OFF_W'(1);
                    end
                end
                OP_COMMIT: begin
                    if (drop) begin
                        n_status   = STAT_FULL;
                        n_dropping = 1'b0;
                    end else begin
                        len_we       = 1'b1;
                        n_write_slot = ring_next(r_write_slot);
                        n_count      = r_count + CNT_W'(1);
                    end
                    n_write_offset = '0;
                end
                OP_POP: begin
                    if (r_count == '0) begin
                        n_status = STAT_EMPTY;
                    end else begin
                        n_head_len = LEN_W'(head_len);
                        if (head_len != '0) begin
                            store_req.rd_en = 1'b1;
                            store_req.addr  = byte_addr(r_read_slot, r_read_offset);
                            n_use_mem       = 1'b1;
                            n_read_offset   = rd_next;
                        end
                        if (head_len == '0 || rd_next >= head_len) begin
                            n_rec_end     = 1'b1;
                            n_read_offset = '0;
                            n_read_slot   = ring_next(r_read_slot);
                            n_count       = r_count - CNT_W'(1);
                        end
                    end
                end
                default: begin
                end
            endcase
            if (n_use_mem) begin
                n_state     = ST_READ;
                n_out_valid = 1'b0;
            end else begin
                n_out_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_write_slot   <= '0;
            r_read_slot    <= '0;
            r_count        <= '0;
            r_write_offset <= '0;
            r_read_offset  <= '0;
            r_dropping     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_write_slot   <= n_write_slot;
            r_read_slot    <= n_read_slot;
            r_count        <= n_count;
            r_write_offset <= n_write_offset;
            r_read_offset  <= n_read_offset;
            r_dropping     <= n_dropping;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (len_we) begin
            r_slot_len[r_write_slot] <= r_write_offset;
        end
        if (accept) begin
            r_status   <= n_status;
            r_rec_end  <= n_rec_end;
            r_head_len <= n_head_len;
            r_use_mem  <= n_use_mem;
        end
    end

    rrq_byte_store u_byte_store (
        .i_clk     (i_clk),
        .i_req     (store_req),
        .o_rd_data (rd_data)
    );

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_out_byte    = r_use_mem ? rd_data : '0;
    assign o_record_end  = r_rec_end;
    assign o_head_length = r_head_len;
    assign o_occupancy   = OCC_W'(r_count);

    `RRQ_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(SLOTS))
    `RRQ_ASSERT_ALWAYS(a_offset_bound, i_clk, i_rst_n, r_write_offset <= OFF_W'(SLOT_BYTES))
    `RRQ_ASSERT_ALWAYS(a_drop_no_data, i_clk, i_rst_n, !r_dropping || r_write_offset == '0)
    `RRQ_ASSERT_ALWAYS(a_read_slot_free, i_clk, i_rst_n, r_state != ST_READ || !r_out_valid)
    `RRQ_ASSERT_NEXT(a_read_completes, i_clk, i_rst_n, r_state == ST_READ, o_out_valid && r_use_mem)

endmodule
